### sv/penum_pkg.sv
`default_nettype none
package penum_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_ELEMENTS  = 8;
   localparam int DEF_ELEMENT_WIDTH = 32;

   // fixed field widths
   localparam int COUNT_W     = 4;   // element_count register
   localparam int IDX_W       = 3;   // one entry of the index order, a place, a position
   localparam int VALUE_W     = 32;  // element_value and out_value
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // request kinds carried on req_tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_NEXT = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic cfg_write;     // take csr_data into the element count
      logic load_store;    // write the request value into the element store
      logic restart;       // identity order, clear started and finished
      logic set_started;
      logic set_finished;
      logic seed_init;     // point at the last active place
      logic hold_rd;       // keep the order entry read this cycle
      logic ptr_dec;
      logic ptr_inc;
      logic pivot;         // record pivot place and entry, restart the successor scan
      logic swap;          // exchange pivot with its successor, set up the reversal
      logic rd_hi;         // read the order at the upper reversal pointer
      logic rev_write;     // finish one exchange of the reversal
      logic emit_init;     // point at place 0
      logic push;          // load one element result into the output register
      logic push_exh;      // load the exhausted result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic started;
      logic finished;
      logic n_lt2;
      logic rd_lt_hold;
      logic rd_gt_pval;
      logic ptr_zero;
      logic lo_lt_hi;
      logic emit_last;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

### sv/penum_ctrl.sv
`default_nettype none
module penum_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   input  wire                   req_func,
   input  wire                   csr_valid,
   input  penum_pkg::sts_type    sts,
   output penum_pkg::cmd_type    cmd,
   output logic                  req_tready,
   output logic                  csr_ready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SEED  = 3'd1;
   localparam logic [2:0] ST_SCANP = 3'd2;
   localparam logic [2:0] ST_SCANQ = 3'd3;
   localparam logic [2:0] ST_REVA  = 3'd4;
   localparam logic [2:0] ST_REVB  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;
   localparam logic [2:0] ST_EXH   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // a csr write takes the idle cycle ahead of any request
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
               cmd.restart   = 1'b1;
            end else if (req_tvalid) begin
               if (req_func == penum_pkg::FUNC_LOAD) begin
                  cmd.load_store = 1'b1;
                  cmd.restart    = 1'b1;
               end else if (sts.finished) begin
                  state_in = ST_EXH;
               end else if (!sts.started) begin
                  cmd.set_started = 1'b1;
                  cmd.emit_init   = 1'b1;
                  state_in        = ST_EMIT;
               end else if (sts.n_lt2) begin
                  cmd.set_finished = 1'b1;
                  state_in         = ST_EXH;
               end else begin
                  cmd.seed_init = 1'b1;
                  state_in      = ST_SEED;
               end
            end
         end
         ST_SEED: begin
            cmd.hold_rd = 1'b1;
            cmd.ptr_dec = 1'b1;
            state_in    = ST_SCANP;
         end
         ST_SCANP: begin
            if (sts.rd_lt_hold) begin
               cmd.pivot = 1'b1;
               state_in  = ST_SCANQ;
            end else if (sts.ptr_zero) begin
               cmd.set_finished = 1'b1;
               state_in         = ST_EXH;
            end else begin
               cmd.hold_rd = 1'b1;
               cmd.ptr_dec = 1'b1;
            end
         end
         ST_SCANQ: begin
            if (sts.rd_gt_pval) begin
               cmd.swap = 1'b1;
               state_in = ST_REVA;
            end else begin
               cmd.ptr_dec = 1'b1;
            end
         end
         ST_REVA: begin
            if (sts.lo_lt_hi) begin
               cmd.hold_rd = 1'b1;
               state_in    = ST_REVB;
            end else begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_REVB: begin
            cmd.rd_hi     = 1'b1;
            cmd.rev_write = 1'b1;
            state_in      = ST_REVA;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.ptr_inc = 1'b1;
               end
            end
         end
         ST_EXH: begin
            if (sts.out_free) begin
               cmd.push_exh = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

### sv/penum_dpath.sv
`default_nettype none
module penum_dpath #(
   parameter int MAX_ELEMENTS  = penum_pkg::DEF_MAX_ELEMENTS,
   parameter int ELEMENT_WIDTH = penum_pkg::DEF_ELEMENT_WIDTH
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  penum_pkg::cmd_type                     cmd,
   output penum_pkg::sts_type                     sts,
   input  wire  [penum_pkg::COUNT_W-1:0]          csr_data,
   input  wire  [penum_pkg::IDX_W-1:0]            req_position,
   input  wire  [penum_pkg::VALUE_W-1:0]          req_value,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [penum_pkg::VALUE_W-1:0]          rsp_value,
   output logic [penum_pkg::IDX_W-1:0]            rsp_place,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser
);

   localparam int PosW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int IdxW = penum_pkg::IDX_W;
   localparam int CntW = penum_pkg::COUNT_W;

   logic [ELEMENT_WIDTH-1:0] store_ff [MAX_ELEMENTS];
   logic [IdxW-1:0]          ord_ff   [MAX_ELEMENTS];

   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [IdxW-1:0] ptr_ff, hi_ff, hold_ff, pivot_ff, pval_ff;
   logic            started_ff, finished_ff;
   logic            rvalid_ff;
   logic [penum_pkg::VALUE_W-1:0] rvalue_ff;
   logic [IdxW-1:0] rplace_ff;
   logic            rlast_ff, rexh_ff;

   logic [IdxW-1:0] nm1;
   logic [IdxW-1:0] rd_addr;
   logic [IdxW-1:0] rd;
   logic [63:0]     load_wide;
   logic [63:0]     elem_wide;
   logic            out_free;

   assign nm1       = IdxW'(cnt_ff - CntW'(1));
   assign rd_addr   = cmd.rd_hi ? hi_ff : ptr_ff;
   assign rd        = ord_ff[rd_addr[PosW-1:0]];
   assign load_wide = 64'(signed'(req_value));
   assign elem_wide = 64'(signed'(store_ff[rd[PosW-1:0]]));
   assign out_free  = !rvalid_ff || rsp_tready;

   // clamp the written count into 1..MAX_ELEMENTS
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cfg_write) begin
         if (csr_data == '0) begin
            cnt_in = CntW'(1);
         end else if (csr_data > CntW'(MAX_ELEMENTS)) begin
            cnt_in = CntW'(MAX_ELEMENTS);
         end else begin
            cnt_in = csr_data;
         end
      end
   end

   always_comb begin
      sts.started    = started_ff;
      sts.finished   = finished_ff;
      sts.n_lt2      = (cnt_ff < CntW'(2));
      sts.rd_lt_hold = (rd < hold_ff);
      sts.rd_gt_pval = (rd > pval_ff);
      sts.ptr_zero   = (ptr_ff == '0);
      sts.lo_lt_hi   = (ptr_ff < hi_ff);
      sts.emit_last  = (ptr_ff == nm1);
      sts.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_store && (32'(req_position) < 32'(MAX_ELEMENTS))) begin
         store_ff[req_position[PosW-1:0]] <= load_wide[ELEMENT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= CntW'(MAX_ELEMENTS);
         started_ff  <= 1'b0;
         finished_ff <= 1'b0;
         rvalid_ff   <= 1'b0;
         for (int i = 0; i < MAX_ELEMENTS; i++) begin
            ord_ff[i] <= IdxW'(i);
         end
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.restart) begin
            started_ff  <= 1'b0;
            finished_ff <= 1'b0;
            for (int i = 0; i < MAX_ELEMENTS; i++) begin
               ord_ff[i] <= IdxW'(i);
            end
         end else begin
            if (cmd.set_started) begin
               started_ff <= 1'b1;
            end
            if (cmd.set_finished) begin
               finished_ff <= 1'b1;
            end
            if (cmd.swap) begin
               ord_ff[pivot_ff[PosW-1:0]] <= rd;
               ord_ff[ptr_ff[PosW-1:0]]   <= pval_ff;
            end
            if (cmd.rev_write) begin
               ord_ff[ptr_ff[PosW-1:0]] <= rd;
               ord_ff[hi_ff[PosW-1:0]]  <= hold_ff;
            end
         end
         if (cmd.push || cmd.push_exh) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
      end
   end

   // scan pointers, held entries and the output payload
   always_ff @(posedge clock) begin
      if (cmd.seed_init || cmd.pivot) begin
         ptr_ff <= nm1;
      end else if (cmd.emit_init) begin
         ptr_ff <= '0;
      end else if (cmd.swap) begin
         ptr_ff <= pivot_ff + IdxW'(1);
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_ff - IdxW'(1);
      end else if (cmd.ptr_inc || cmd.rev_write) begin
         ptr_ff <= ptr_ff + IdxW'(1);
      end
      if (cmd.swap) begin
         hi_ff <= nm1;
      end else if (cmd.rev_write) begin
         hi_ff <= hi_ff - IdxW'(1);
      end
      if (cmd.hold_rd) begin
         hold_ff <= rd;
      end
      if (cmd.pivot) begin
         pivot_ff <= ptr_ff;
         pval_ff  <= rd;
      end
      if (cmd.push) begin
         rvalue_ff <= elem_wide[penum_pkg::VALUE_W-1:0];
         rplace_ff <= ptr_ff;
         rlast_ff  <= (ptr_ff == nm1);
         rexh_ff   <= 1'b0;
      end else if (cmd.push_exh) begin
         rvalue_ff <= '0;
         rplace_ff <= '0;
         rlast_ff  <= 1'b1;
         rexh_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_value  = rvalue_ff;
   assign rsp_place  = rplace_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = rexh_ff;

endmodule
`default_nettype wire

### sv/permutation_enumerator_unit.sv
`default_nettype none
// Channel   Ports                                  Moves
// req       req_tvalid/tready, tdata[40], tuser    load or next request
// rsp       rsp_tvalid/tready, tdata[40], tlast,   one permutation element, or the
//           tuser                                  exhausted marker
// csr       csr_valid/ready, csr_data[4]           element count (1..MAX_ELEMENTS)
//
// A load request writes one element into the store, restarts the order and gives
// no result. A next request walks the index order through one shared read port:
// a seed step, the pivot scan, the successor scan and the suffix reversal, whose
// exchanges each read the lower entry, then the upper, and write both. It then
// emits each element in order of place. The first next after a restart emits the
// identity order; a next after the last permutation gives the exhausted marker.
// Reset is synchronous: the count returns to MAX_ELEMENTS, the order to identity.
// A stalled rsp_tready holds the output register and freezes the emit sequence.
// Requests and csr writes are taken only while the unit is idle; a csr write
// offered together with a request goes first and holds the request off.
module permutation_enumerator_unit #(
   parameter int MAX_ELEMENTS  = penum_pkg::DEF_MAX_ELEMENTS,
   parameter int ELEMENT_WIDTH = penum_pkg::DEF_ELEMENT_WIDTH
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // request
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [penum_pkg::REQ_TDATA_W-1:0]   req_tdata,  // load_position[2:0], element_value[34:3], zero pad
   input  wire                                 req_tuser,  // func
   // result
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [penum_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // out_value[31:0], out_place[34:32], zero pad
   output logic                                rsp_tlast,  // last_of_perm
   output logic                                rsp_tuser,  // exhausted
   // element count register
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [penum_pkg::COUNT_W-1:0]       csr_data
);

   localparam int ValW = penum_pkg::VALUE_W;
   localparam int IdxW = penum_pkg::IDX_W;

   penum_pkg::cmd_type cmd;
   penum_pkg::sts_type sts;

   logic [ValW-1:0] rsp_value;
   logic [IdxW-1:0] rsp_place;

   // sequence each request
   penum_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .csr_valid  (csr_valid),
      .sts        (sts),
      .cmd        (cmd),
      .req_tready (req_tready),
      .csr_ready  (csr_ready)
   );

   // hold the store, the index order and the output register
   penum_dpath #(
      .MAX_ELEMENTS  (MAX_ELEMENTS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .csr_data     (csr_data),
      .req_position (req_tdata[IdxW-1:0]),
      .req_value    (req_tdata[IdxW+ValW-1:IdxW]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_place    (rsp_place),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

   // pack the result fields, value in the low bits
   assign rsp_tdata = {{(penum_pkg::RSP_TDATA_W - ValW - IdxW){1'b0}}, rsp_place, rsp_value};

endmodule
`default_nettype wire
